// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the particle update RTL.
// Depends on nothing; a file that asserts needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPU_ASSERT(lbl, prop, msg)
`define LPU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/lpu_pkg.sv =====
// Types, codes and helpers for the Langevin particle update unit.
// Used by every module of the block; depends on nothing.
package lpu_pkg;

  localparam int MASS_W  = 32;
  localparam int DIV_DW  = 64;
  localparam int SQRT_NW = 64;
  localparam int CFG_IW  = 3;

  localparam logic [1:0] REQ_DRIFT     = 2'd0;
  localparam logic [1:0] REQ_ATOM      = 2'd1;
  localparam logic [1:0] REQ_RESERVOIR = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_ATOM_DECAY      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_RESERVOIR_DECAY = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_HALF_STEP       = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_HALF_KICK       = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_NOISE_SCALE     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_RESERVOIR_MASS  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_TARGET_POTENTIAL = 3'd6;

  localparam logic [15:0] RST_DECAY      = 16'd65000;
  localparam logic [15:0] RST_HALF_STEP  = 16'd328;
  localparam logic [15:0] RST_HALF_KICK  = 16'd328;
  localparam logic [31:0] RST_ONE_Q16    = 32'd65536;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_DRIFT,
    MODE_FINISH
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] x;
    logic [31:0] v;
    logic [15:0] decay;
    logic        neg;
  } kick_pay_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] x;
    logic [31:0] v;
    logic [15:0] decay;
    logic [31:0] dv;
    logic [15:0] g;
  } root_pay_t;

  localparam int KICK_PW = $bits(kick_pay_t);
  localparam int ROOT_PW = $bits(root_pay_t);

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [39:0] val);
    logic [31:0] res;
    if (val > SAT_MAX) begin
      res = 32'h7fff_ffff;
    end else if (val < SAT_MIN) begin
      res = 32'h8000_0000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/lpu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on lpu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lpu_div import lpu_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int PW = KICK_PW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     in_dividend,
  input  logic [MASS_W-1:0] in_divisor,
  input  logic [PW-1:0]     in_pay,
  output logic              out_valid,
  output logic [DW-1:0]     out_quot,
  output logic [PW-1:0]     out_pay
);

  logic [DW:0]         vld_r;
  logic [DW-1:0]       dq_r  [DW+1];
  logic [MASS_W-1:0]   rem_r [DW+1];
  logic [MASS_W-1:0]   dvs_r [DW+1];
  logic [PW-1:0]       pay_r [DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r[0]  <= in_dividend;
      rem_r[0] <= '0;
      dvs_r[0] <= in_divisor;
      pay_r[0] <= in_pay;
    end
  end

  // The dividend shifts out of the top of dq while quotient bits enter below.
  for (genvar k = 0; k < DW; k++) begin : g_stg
    logic [MASS_W:0] trial;
    logic            take;
    assign trial = {rem_r[k], dq_r[k][DW-1]};
    assign take  = trial >= {1'b0, dvs_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? MASS_W'(trial - {1'b0, dvs_r[k]}) : trial[MASS_W-1:0];
        dq_r[k+1]  <= {dq_r[k][DW-2:0], take};
        dvs_r[k+1] <= dvs_r[k];
        pay_r[k+1] <= pay_r[k];
      end
    end
  end

  assign out_valid = vld_r[DW];
  assign out_quot  = dq_r[DW];
  assign out_pay   = pay_r[DW];

  `LPU_ASSERT(a_div_rem_lt, vld_r[DW] && (dvs_r[DW] != '0) |-> rem_r[DW] < dvs_r[DW], "divider remainder not below divisor")
  `LPU_ASSERT(a_div_stall_hold, !en |=> $stable(vld_r), "divider valid bits moved during a stall")
  `LPU_ASSERT(a_div_entry, en |=> vld_r[0] == $past(in_valid), "divider lost an entering item")

endmodule

// ===== rtl/lpu_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side payload.
// Depends on lpu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lpu_sqrt import lpu_pkg::*; #(
  parameter int NW = SQRT_NW,
  parameter int PW = ROOT_PW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_radicand,
  input  logic [PW-1:0]     in_pay,
  output logic              out_valid,
  output logic [NW/2-1:0]   out_root,
  output logic [PW-1:0]     out_pay
);

  localparam int ST  = NW / 2;
  localparam int RTW = NW / 2;
  localparam int RMW = RTW + 2;

  logic [ST:0]      vld_r;
  logic [NW-1:0]    n_r    [ST+1];
  logic [RMW-1:0]   rem_r  [ST+1];
  logic [RTW-1:0]   root_r [ST+1];
  logic [PW-1:0]    pay_r  [ST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= in_radicand;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      pay_r[0]  <= in_pay;
    end
  end

  // Each stage brings down two radicand bits and settles one root bit.
  for (genvar k = 0; k < ST; k++) begin : g_stg
    logic [RMW+1:0] cur;
    logic [RMW+1:0] tst;
    logic           take;
    assign cur  = {rem_r[k], n_r[k][NW-1 -: 2]};
    assign tst  = (RMW+2)'({root_r[k], 2'b01});
    assign take = cur >= tst;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? RMW'(cur - tst) : RMW'(cur);
        n_r[k+1]    <= {n_r[k][NW-3:0], 2'b00};
        root_r[k+1] <= {root_r[k][RTW-2:0], take};
        pay_r[k+1]  <= pay_r[k];
      end
    end
  end

  assign out_valid = vld_r[ST];
  assign out_root  = root_r[ST];
  assign out_pay   = pay_r[ST];

  `LPU_ASSERT(a_sqrt_rem_bound, vld_r[ST] |-> rem_r[ST] <= {root_r[ST], 1'b0}, "root remainder above twice the root")
  `LPU_ASSERT(a_sqrt_stall_hold, !en |=> $stable(vld_r), "root valid bits moved during a stall")
  `LPU_ASSERT(a_sqrt_consumed, vld_r[ST] |-> n_r[ST] == '0, "radicand bits left over at the root output")

endmodule

// ===== rtl/langevin_particle_update_unit.sv =====
// Top level of the Langevin particle update unit: registers, kick and drift
// arithmetic around the lpu_div and lpu_sqrt pipelines. Depends on lpu_pkg.
//
//  Channel   Direction  Handshake                 Contents
//  in_       slave      in_tvalid / in_tready     one coordinate item
//  out_      master     out_tvalid / out_tready   updated position, velocity
//  cfg_      slave      cfg_valid / cfg_ready     register index and value
//
// One item enters per cycle unless the output stalls; results leave in entry order.
// Most of the pipeline depth lies in the 64-stage divider and the 32-stage square root.
// Reset (rst_n low, synchronous) empties the pipeline and loads default registers.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
`include "assert_macros.svh"
module langevin_particle_update_unit import lpu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // mass[31:0], position_in[63:32], velocity_in[95:64], force_in[127:96],
  // gauss_sample[143:128]
  input  logic [143:0]       in_tdata,
  // req_type[1:0], in_group[2]
  input  logic [2:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // position_out[31:0], velocity_out[63:32]
  output logic [63:0]        out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [31:0]        cfg_data
);

  // Configuration registers
  logic [15:0] atom_decay_r, res_decay_r, half_step_r, half_kick_r;
  logic [31:0] noise_scale_r, res_mass_r, target_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_decay_r  <= RST_DECAY;
      res_decay_r   <= RST_DECAY;
      half_step_r   <= RST_HALF_STEP;
      half_kick_r   <= RST_HALF_KICK;
      noise_scale_r <= RST_ONE_Q16;
      res_mass_r    <= RST_ONE_Q16;
      target_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATOM_DECAY:       atom_decay_r  <= cfg_data[15:0];
        CFG_RESERVOIR_DECAY:  res_decay_r   <= cfg_data[15:0];
        CFG_HALF_STEP:        half_step_r   <= cfg_data[15:0];
        CFG_HALF_KICK:        half_kick_r   <= cfg_data[15:0];
        CFG_NOISE_SCALE:      noise_scale_r <= cfg_data;
        CFG_RESERVOIR_MASS:   res_mass_r    <= cfg_data;
        CFG_TARGET_POTENTIAL: target_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Input field unpacking
  logic [1:0]  req_type;
  logic        in_group;
  logic [31:0] in_mass, in_x, in_v, in_f;
  logic [15:0] in_g;
  assign req_type = in_tuser[1:0];
  assign in_group = in_tuser[2];
  assign in_mass  = in_tdata[31:0];
  assign in_x     = in_tdata[63:32];
  assign in_v     = in_tdata[95:64];
  assign in_f     = in_tdata[127:96];
  assign in_g     = in_tdata[143:128];

  // Stage A: select the kind of work and its operands
  mode_t              a_mode_nxt;
  logic               is_res;
  logic [31:0]        a_mass_sel;
  logic               a_vld_r;
  mode_t              a_mode_r;
  logic signed [33:0] a_force_r;
  logic [31:0]        a_mass_r, a_x_r, a_v_r;
  logic [15:0]        a_decay_r, a_g_r;

  assign is_res     = req_type == REQ_RESERVOIR;
  assign a_mass_sel = is_res ? res_mass_r : in_mass;

  always_comb begin
    a_mode_nxt = MODE_PASS;
    if (is_res || (req_type == REQ_ATOM && in_group)) begin
      a_mode_nxt = MODE_FINISH;
    end else if (req_type == REQ_DRIFT && in_group) begin
      a_mode_nxt = MODE_DRIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode_r  <= a_mode_nxt;
      a_force_r <= is_res ? 34'(signed'(target_r)) - 34'(signed'(in_f))
                          : 34'(signed'(in_f));
      a_mass_r  <= (a_mass_sel == '0) ? 32'd1 : a_mass_sel;
      a_decay_r <= is_res ? res_decay_r : atom_decay_r;
      a_x_r     <= in_x;
      a_v_r     <= in_v;
      a_g_r     <= in_g;
    end
  end

  // Stage B: kick numerator and decay squared
  logic               b_vld_r;
  mode_t              b_mode_r;
  logic signed [50:0] b_num_r;
  logic [31:0]        b_dsq_r, b_mass_r, b_x_r, b_v_r;
  logic [15:0]        b_decay_r, b_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mode_r  <= a_mode_r;
      b_num_r   <= 51'(signed'({1'b0, half_kick_r})) * 51'(a_force_r);
      b_dsq_r   <= 32'(a_decay_r) * 32'(a_decay_r);
      b_mass_r  <= a_mass_r;
      b_decay_r <= a_decay_r;
      b_x_r     <= a_x_r;
      b_v_r     <= a_v_r;
      b_g_r     <= a_g_r;
    end
  end

  // Stage C: kick magnitude and noise_scale * decay^2
  logic               c_vld_r;
  mode_t              c_mode_r;
  logic               c_neg_r;
  logic [49:0]        c_mag_r;
  logic [63:0]        c_p_r;
  logic [31:0]        c_mass_r, c_x_r, c_v_r;
  logic [15:0]        c_decay_r, c_g_r;
  logic signed [50:0] b_abs;

  assign b_abs = b_num_r[50] ? -b_num_r : b_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mode_r  <= b_mode_r;
      c_neg_r   <= b_num_r[50];
      c_mag_r   <= b_abs[49:0];
      c_p_r     <= 64'(noise_scale_r) * 64'(b_dsq_r);
      c_mass_r  <= b_mass_r;
      c_decay_r <= b_decay_r;
      c_x_r     <= b_x_r;
      c_v_r     <= b_v_r;
      c_g_r     <= b_g_r;
    end
  end

  // (2^32 - decay^2) * noise_scale, formed as a shift minus the product
  logic [DIV_DW-1:0] beta_num;
  kick_pay_t         kick_in_pay, kick_out_pay;
  logic              kick_vld, beta_vld;
  logic [DIV_DW-1:0] kick_q, beta_q;
  logic [15:0]       beta_g;

  assign beta_num = {noise_scale_r, 32'd0} - c_p_r;
  assign kick_in_pay = '{mode: c_mode_r, x: c_x_r, v: c_v_r, decay: c_decay_r, neg: c_neg_r};

  lpu_div #(.DW(DIV_DW), .PW(KICK_PW)) u_kick_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (c_vld_r),
    .in_dividend (DIV_DW'(c_mag_r)),
    .in_divisor  (c_mass_r),
    .in_pay      (kick_in_pay),
    .out_valid   (kick_vld),
    .out_quot    (kick_q),
    .out_pay     (kick_out_pay)
  );

  lpu_div #(.DW(DIV_DW), .PW(16)) u_beta_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (c_vld_r),
    .in_dividend (beta_num),
    .in_divisor  (c_mass_r),
    .in_pay      (c_g_r),
    .out_valid   (beta_vld),
    .out_quot    (beta_q),
    .out_pay     (beta_g)
  );

  // Signed, saturated kick from the quotient magnitude
  logic        kick_big;
  logic [31:0] dv;
  root_pay_t   root_in_pay, root_out_pay;
  logic        root_vld;
  logic [31:0] beta;

  assign kick_big = |kick_q[DIV_DW-1:31];
  always_comb begin
    if (kick_out_pay.neg) begin
      dv = kick_big ? 32'h8000_0000 : -kick_q[31:0];
    end else begin
      dv = kick_big ? 32'h7fff_ffff : kick_q[31:0];
    end
  end

  assign root_in_pay = '{mode: kick_out_pay.mode, x: kick_out_pay.x, v: kick_out_pay.v,
                         decay: kick_out_pay.decay, dv: dv, g: beta_g};

  lpu_sqrt #(.NW(SQRT_NW), .PW(ROOT_PW)) u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (kick_vld),
    .in_radicand (beta_q),
    .in_pay      (root_in_pay),
    .out_valid   (root_vld),
    .out_root    (beta),
    .out_pay     (root_out_pay)
  );

  // Stage E: first kick
  logic        e_vld_r;
  mode_t       e_mode_r;
  logic [31:0] e_x_r, e_v_r, e_dv_r, e_beta_r, e_v1_r;
  logic [15:0] e_decay_r, e_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_mode_r  <= root_out_pay.mode;
      e_x_r     <= root_out_pay.x;
      e_v_r     <= root_out_pay.v;
      e_dv_r    <= root_out_pay.dv;
      e_decay_r <= root_out_pay.decay;
      e_g_r     <= root_out_pay.g;
      e_beta_r  <= beta;
      e_v1_r    <= sat32(40'(signed'(root_out_pay.v)) + 40'(signed'(root_out_pay.dv)));
    end
  end

  // Stage F: friction and noise products
  logic               f_vld_r;
  mode_t              f_mode_r;
  logic [31:0]        f_x_r, f_v_r, f_dv_r;
  logic signed [48:0] f_vdec_r, f_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mode_r  <= e_mode_r;
      f_x_r     <= e_x_r;
      f_v_r     <= e_v_r;
      f_dv_r    <= e_dv_r;
      f_vdec_r  <= 49'(signed'({1'b0, e_decay_r})) * 49'(signed'(e_v1_r));
      f_noise_r <= 49'(signed'({1'b0, e_beta_r})) * 49'(signed'(e_g_r));
    end
  end

  // Stage G: scaled velocity plus noise; arithmetic shifts round toward minus infinity
  logic        g_vld_r;
  mode_t       g_mode_r;
  logic [31:0] g_x_r, g_v_r, g_dv_r, g_v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_mode_r <= f_mode_r;
      g_x_r    <= f_x_r;
      g_v_r    <= f_v_r;
      g_dv_r   <= f_dv_r;
      g_v3_r   <= sat32(40'(f_vdec_r >>> 16) + 40'(f_noise_r >>> 12));
    end
  end

  // Stage H: second kick, then pick the velocity that drives the drift
  logic        h_vld_r;
  mode_t       h_mode_r;
  logic [31:0] h_x_r, h_vo_r, h_v4;

  assign h_v4 = sat32(40'(signed'(g_v3_r)) + 40'(signed'(g_dv_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_mode_r <= g_mode_r;
      h_x_r    <= g_x_r;
      h_vo_r   <= (g_mode_r == MODE_FINISH) ? h_v4 : g_v_r;
    end
  end

  // Stage I: drift product
  logic               i_vld_r;
  mode_t              i_mode_r;
  logic [31:0]        i_x_r, i_vo_r;
  logic signed [48:0] i_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (en) begin
      i_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_mode_r <= h_mode_r;
      i_x_r    <= h_x_r;
      i_vo_r   <= h_vo_r;
      i_px_r   <= 49'(signed'({1'b0, half_step_r})) * 49'(signed'(h_vo_r));
    end
  end

  // Output register
  logic [31:0] out_x_r, out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= i_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= (i_mode_r == MODE_PASS) ? i_x_r
               : sat32(40'(signed'(i_x_r)) + 40'(i_px_r >>> 16));
      out_v_r <= i_vo_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_v_r, out_x_r};

  `LPU_ASSERT(a_div_lockstep, kick_vld == beta_vld, "kick and noise dividers out of step")
  `LPU_ASSERT(a_mass_nonzero, c_vld_r |-> c_mass_r != '0, "zero divisor entered the dividers")
  `LPU_ASSERT(a_out_from_pipe, $rose(out_tvalid) |-> $past(i_vld_r), "result appeared without an item")
  `LPU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid straight after reset")

endmodule

// ===== verif/tb_langevin_particle_update_unit.sv =====
// Self-checking testbench for langevin_particle_update_unit: random and directed
// coordinate items checked against an in-bench predictor. Depends on lpu_pkg.
`timescale 1ns / 1ps
module tb_langevin_particle_update_unit;
  import lpu_pkg::*;

  localparam int LATENCY_WAIT = 140;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  langevin_particle_update_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copies of the block's registers.
  logic [15:0] sh_atom_decay = RST_DECAY;
  logic [15:0] sh_res_decay = RST_DECAY;
  logic [15:0] sh_half_step = RST_HALF_STEP;
  logic [15:0] sh_half_kick = RST_HALF_KICK;
  logic [31:0] sh_noise_scale = RST_ONE_Q16;
  logic [31:0] sh_res_mass = RST_ONE_Q16;
  logic [31:0] sh_target = '0;

  logic [63:0] expected_coords[$];
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int tx_gap_pct = 20;
  int rx_stall_pct = 20;
  int rx_hold_request = 0;

  function automatic longint clamp32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint half_drift(longint x, longint v);
    return clamp32(x + ((longint'(sh_half_step) * v) >>> 16));
  endfunction

  // Kick, friction and noise, kick, drift; returns {velocity, position}.
  function automatic logic [63:0] langevin_finish(longint x, longint v, longint frc,
                                                  logic [31:0] mass, logic [15:0] decay,
                                                  longint g);
    longint num, dv, noise, xo;
    logic [63:0] mag, q, s, d64, beta, m64;
    m64 = (mass == 0) ? 64'd1 : {32'd0, mass};
    num = longint'(sh_half_kick) * frc;
    mag = (num < 0) ? -num : num;
    q = mag / m64;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    dv = clamp32((num < 0) ? -longint'(q) : longint'(q));
    v = clamp32(v + dv);
    v = (longint'(decay) * v) >>> 16;
    d64 = {48'd0, decay};
    s = 64'h1_0000_0000 - d64 * d64;
    beta = int_sqrt((s * {32'd0, sh_noise_scale}) / m64);
    noise = (longint'(beta) * g) >>> 12;
    v = clamp32(v + noise);
    v = clamp32(v + dv);
    xo = half_drift(x, v);
    return {v[31:0], xo[31:0]};
  endfunction

  function automatic logic [63:0] predict_coords(logic [1:0] kind, logic grp,
                                                 logic [31:0] mass, logic [31:0] xi,
                                                 logic [31:0] vi, logic [31:0] fi,
                                                 logic [15:0] gi);
    longint x, v, f, g, rf;
    logic [63:0] r;
    x = longint'(signed'(xi));
    v = longint'(signed'(vi));
    f = longint'(signed'(fi));
    g = longint'(signed'(gi));
    r = {vi, xi};
    if (kind == REQ_DRIFT && grp) begin
      r[31:0] = 32'(half_drift(x, v));
    end else if (kind == REQ_ATOM && grp) begin
      r = langevin_finish(x, v, f, mass, sh_atom_decay, g);
    end else if (kind == REQ_RESERVOIR) begin
      rf = -f + longint'(signed'(sh_target));
      r = langevin_finish(x, v, rf, sh_res_mass, sh_res_decay, g);
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] kind, logic grp, logic [31:0] mass, logic [31:0] x,
                           logic [31:0] v, logic [31:0] f, logic [15:0] g);
    int gap;
    in_tdata = {g, f, v, x, mass};
    in_tuser = {grp, kind};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_coords.push_back(predict_coords(kind, grp, mass, x, v, f, g));
    items_sent++;
    @(negedge clk);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATOM_DECAY: sh_atom_decay = val[15:0];
      CFG_RESERVOIR_DECAY: sh_res_decay = val[15:0];
      CFG_HALF_STEP: sh_half_step = val[15:0];
      CFG_HALF_KICK: sh_half_kick = val[15:0];
      CFG_NOISE_SCALE: sh_noise_scale = val;
      CFG_RESERVOIR_MASS: sh_res_mass = val;
      CFG_TARGET_POTENTIAL: sh_target = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_coords.size() != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
      3, 4: return $urandom_range(0, 1) ? $urandom_range(0, 65535 * 16)
                                         : -$urandom_range(0, 65535 * 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 7))
      0: return $urandom_range(1, 255);
      1: return $urandom | 32'h1;
      2: return 32'hffff_ffff;
      default: return $urandom_range(1 << 12, 1 << 24);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [1:0] kind;
    logic [15:0] g;
    repeat (count) begin
      kind = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      g = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
      send_item(kind, $urandom_range(0, 7) != 0, pick_mass(), pick_value(), pick_value(),
                pick_value(), g);
    end
  endtask

  task automatic test_directed();
    send_item(REQ_DRIFT, 1'b1, 32'd65536, 32'd1000, 32'd65536, 32'd0, 16'd0);
    send_item(REQ_DRIFT, 1'b1, 32'd65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 16'd0);
    send_item(REQ_DRIFT, 1'b1, 32'd65536, 32'h8000_0000, 32'h8000_0000, 32'd5, 16'd9);
    send_item(REQ_DRIFT, 1'b0, 32'd65536, 32'd77, 32'd99, 32'd1, 16'd1);
    send_item(REQ_ATOM, 1'b1, 32'd65536, 32'd0, 32'd65536, 32'd65536, 16'd4096);
    send_item(REQ_ATOM, 1'b1, 32'd1, 32'd0, 32'd0, 32'h7fff_ffff, 16'h7fff);
    send_item(REQ_ATOM, 1'b1, 32'd1, 32'd0, 32'd0, 32'h8000_0000, 16'h8000);
    // A zero mass is treated as the smallest representable mass.
    send_item(REQ_ATOM, 1'b1, 32'd0, 32'd12345, 32'h7fff_ffff, 32'd100, 16'h7fff);
    send_item(REQ_ATOM, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff,
              16'hffff);
    send_item(REQ_ATOM, 1'b0, 32'd65536, 32'd5, 32'd6, 32'd7, 16'd8);
    send_item(REQ_RESERVOIR, 1'b0, 32'd0, 32'd65536, 32'd100, 32'd65536, 16'd4096);
    send_item(REQ_RESERVOIR, 1'b1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 16'h8000);
    send_item(REQ_RESERVOIR, 1'b1, 32'd65536, 32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 16'h7fff);
    send_item(2'd3, 1'b1, 32'd65536, 32'hdead_beef, 32'h1234_5678, 32'd1, 16'd1);
    send_item(2'd3, 1'b0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
              16'hffff);
    wait_drained();
  endtask

  task automatic test_register_settings();
    write_reg(CFG_ATOM_DECAY, 32'd0);
    write_reg(CFG_RESERVOIR_DECAY, 32'd65535);
    write_reg(CFG_HALF_STEP, 32'd65535);
    write_reg(CFG_HALF_KICK, 32'd65535);
    write_reg(CFG_NOISE_SCALE, 32'hffff_ffff);
    write_reg(CFG_RESERVOIR_MASS, 32'd1);
    write_reg(CFG_TARGET_POTENTIAL, 32'h7fff_ffff);
    send_random(100);
    wait_drained();
    write_reg(CFG_ATOM_DECAY, 32'd65535);
    write_reg(CFG_RESERVOIR_DECAY, 32'd0);
    write_reg(CFG_HALF_STEP, 32'd0);
    write_reg(CFG_HALF_KICK, 32'd0);
    write_reg(CFG_NOISE_SCALE, 32'd0);
    write_reg(CFG_RESERVOIR_MASS, 32'hffff_ffff);
    write_reg(CFG_TARGET_POTENTIAL, 32'h8000_0000);
    send_random(100);
    wait_drained();
    repeat (3) begin
      write_reg(CFG_ATOM_DECAY, $urandom_range(60000, 65535));
      write_reg(CFG_RESERVOIR_DECAY, $urandom_range(0, 65535));
      write_reg(CFG_HALF_STEP, $urandom_range(1, 2000));
      write_reg(CFG_HALF_KICK, $urandom_range(1, 2000));
      write_reg(CFG_NOISE_SCALE, $urandom_range(1, 1 << 20));
      write_reg(CFG_RESERVOIR_MASS, $urandom_range(1, 1 << 24));
      write_reg(CFG_TARGET_POTENTIAL, $urandom);
      tx_gap_pct = $urandom_range(0, 1) ? 0 : 30;
      rx_stall_pct = $urandom_range(0, 1) ? 0 : 30;
      send_random(100);
      wait_drained();
    end
    tx_gap_pct = 20;
    rx_stall_pct = 20;
  endtask

  task automatic test_output_holdoff();
    // The receiver stops long enough for the pipeline to fill and stall the input.
    rx_hold_request = 300;
    tx_gap_pct = 0;
    send_random(150);
    tx_gap_pct = 20;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_random(40);
    wait_drained();
    send_random(40);
    wait_drained();
  endtask

  // Result receiver with its own stall counter.
  int rx_hold_count = 0;
  always @(negedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_count = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_count > 0) begin
      rx_hold_count--;
      out_tready = 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_tready = 1'b0;
      if ($urandom_range(0, 19) == 0) rx_hold_count = $urandom_range(10, 40);
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [63:0] exp_c;
    cycle_count++;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_coords.size() == 0) begin
        $error("result transfer with no expectation waiting: %h", out_tdata);
        error_count++;
      end else begin
        exp_c = expected_coords.pop_front();
        if (out_tdata[31:0] !== exp_c[31:0]) begin
          $error("position_out expected %h actual %h", exp_c[31:0], out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== exp_c[63:32]) begin
          $error("velocity_out expected %h actual %h", exp_c[63:32], out_tdata[63:32]);
          error_count++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_register_settings();
    test_output_holdoff();
    test_drain_pause();
    wait_drained();
    $display("%0d items sent and %0d results checked across six register settings,",
             items_sent, results_seen);
    $display("with drift, atom, reservoir and pass-through items under random stalls.");
    if (error_count == 0 && expected_coords.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
